// ===== rtl/core/lmcd_pkg.sv =====
`timescale 1ns / 1ps

package lmcd_pkg;

  // Rows per module
  localparam int ROWS = 8;

  // Command codes
  localparam logic [2:0] CMD_SET_PIXEL = 3'd0;
  localparam logic [2:0] CMD_CLEAR     = 3'd1;
  localparam logic [2:0] CMD_DRAW      = 3'd2;
  localparam logic [2:0] CMD_BCAST_ROW = 3'd3;
  localparam logic [2:0] CMD_DEV_WRITE = 3'd4;
  localparam logic [2:0] CMD_BLANK     = 3'd5;
  localparam logic [2:0] CMD_INIT      = 3'd6;

  // Configuration register indexes
  localparam logic [0:0] REG_NUM_DEVICES = 1'd0;
  localparam logic [0:0] REG_BRIGHTNESS  = 1'd1;

  // Driver chip register addresses
  localparam logic [3:0] DRV_NOOP      = 4'h0;
  localparam logic [3:0] DRV_DECODE    = 4'h9;
  localparam logic [3:0] DRV_INTENSITY = 4'hA;
  localparam logic [3:0] DRV_SCAN      = 4'hB;
  localparam logic [3:0] DRV_SHUTDOWN  = 4'hC;
  localparam logic [3:0] DRV_TEST      = 4'hF;

  // Input request and output word
  typedef struct packed {
    logic [2:0] command;
    logic [3:0] pixel_x;
    logic [5:0] pixel_y;
    logic       pixel_on;
    logic [3:0] digit_row;
    logic [7:0] row_pattern;
    logic [2:0] target_device;
    logic [3:0] target_addr;
    logic [7:0] target_data;
  } req_t;

  typedef struct packed {
    logic [3:0] word_addr;
    logic [7:0] word_data;
    logic       frame_end;
    logic       last;
  } word_t;

  // Word address and data sources
  typedef enum logic [1:0] {
    ASEL_CONST,
    ASEL_DROW,
    ASEL_CNT,
    ASEL_TGT
  } addr_sel_t;

  typedef enum logic [2:0] {
    DSEL_CONST,
    DSEL_PAT,
    DSEL_BRIGHT,
    DSEL_COL,
    DSEL_TGT
  } data_sel_t;

  // Microprogram steps
  typedef enum logic [3:0] {
    ST_PIXEL,
    ST_CLEAR,
    ST_DRAW,
    ST_BCAST,
    ST_DEVW,
    ST_INIT_TEST,
    ST_INIT_DECODE,
    ST_INIT_SCAN,
    ST_INIT_INTENS,
    ST_INIT_WAKE,
    ST_INIT_BLANK,
    ST_INIT_CLEAR,
    ST_BLANK
  } step_t;

  // One control word
  typedef struct packed {
    addr_sel_t  addr_sel;
    data_sel_t  data_sel;
    logic [3:0] const_addr;
    logic [7:0] const_data;
    logic       fetch;      // read frame buffer in the cycle before each execute cycle
    logic       emit;       // produce one word per execute cycle
    logic       loop_dev;   // repeat over devices
    logic       loop8;      // repeat over eight columns or rows
    logic       pix_wr;     // write back a modified pixel row
    logic       clear;      // clear the active modules
    logic       emit_last;  // final word of this step ends the command
    logic       done;       // command ends after this step
  } ctrl_t;

  // Sequencer to datapath control
  typedef struct packed {
    ctrl_t      ctrl;
    logic       exec;
    logic       dev_last;
    logic       word_last;
    logic [2:0] cnt;
  } seq_ctrl_t;

  // Microcode ROM
  function automatic ctrl_t microcode(input step_t s);
    ctrl_t c;
    c = '0;
    unique case (s)
      ST_PIXEL: begin
        c.fetch  = 1'b1;
        c.pix_wr = 1'b1;
        c.done   = 1'b1;
      end
      ST_CLEAR, ST_INIT_CLEAR: begin
        c.clear = 1'b1;
        c.done  = 1'b1;
      end
      ST_DRAW: begin
        c.fetch     = 1'b1;
        c.emit      = 1'b1;
        c.addr_sel  = ASEL_CNT;
        c.data_sel  = DSEL_COL;
        c.loop_dev  = 1'b1;
        c.loop8     = 1'b1;
        c.emit_last = 1'b1;
        c.done      = 1'b1;
      end
      ST_BCAST: begin
        c.emit      = 1'b1;
        c.addr_sel  = ASEL_DROW;
        c.data_sel  = DSEL_PAT;
        c.loop_dev  = 1'b1;
        c.emit_last = 1'b1;
        c.done      = 1'b1;
      end
      ST_DEVW: begin
        c.emit      = 1'b1;
        c.addr_sel  = ASEL_TGT;
        c.data_sel  = DSEL_TGT;
        c.loop_dev  = 1'b1;
        c.emit_last = 1'b1;
        c.done      = 1'b1;
      end
      ST_INIT_TEST: begin
        c.emit       = 1'b1;
        c.const_addr = DRV_TEST;
        c.loop_dev   = 1'b1;
      end
      ST_INIT_DECODE: begin
        c.emit       = 1'b1;
        c.const_addr = DRV_DECODE;
        c.loop_dev   = 1'b1;
      end
      ST_INIT_SCAN: begin
        c.emit       = 1'b1;
        c.const_addr = DRV_SCAN;
        c.const_data = 8'h07;
        c.loop_dev   = 1'b1;
      end
      ST_INIT_INTENS: begin
        c.emit       = 1'b1;
        c.const_addr = DRV_INTENSITY;
        c.data_sel   = DSEL_BRIGHT;
        c.loop_dev   = 1'b1;
      end
      ST_INIT_WAKE: begin
        c.emit       = 1'b1;
        c.const_addr = DRV_SHUTDOWN;
        c.const_data = 8'h01;
        c.loop_dev   = 1'b1;
      end
      ST_INIT_BLANK: begin
        c.emit      = 1'b1;
        c.addr_sel  = ASEL_CNT;
        c.loop_dev  = 1'b1;
        c.loop8     = 1'b1;
        c.emit_last = 1'b1;
      end
      ST_BLANK: begin
        c.emit      = 1'b1;
        c.addr_sel  = ASEL_CNT;
        c.loop_dev  = 1'b1;
        c.loop8     = 1'b1;
        c.emit_last = 1'b1;
        c.done      = 1'b1;
      end
      default: begin
        c.done = 1'b1;
      end
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/core/lmcd_ram.sv =====
`timescale 1ns / 1ps

module lmcd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/lmcd_seq.sv =====
`timescale 1ns / 1ps

module lmcd_seq #(
  parameter int MAX_MODULES = 4
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  lmcd_pkg::req_t              req,
  input  logic [$clog2(MAX_MODULES+1)-1:0] n,
  output logic                        busy,
  output logic [(MAX_MODULES > 1 ? $clog2(MAX_MODULES) : 1)-1:0] dev,
  output lmcd_pkg::seq_ctrl_t         sc
);

  localparam int NW    = $clog2(MAX_MODULES + 1);
  localparam int IDX_W = (MAX_MODULES > 1) ? $clog2(MAX_MODULES) : 1;

  lmcd_pkg::step_t pc;
  logic             phase;
  logic [IDX_W-1:0] j;
  logic [2:0]       cnt;

  lmcd_pkg::ctrl_t ctrl;
  lmcd_pkg::step_t entry;
  logic            entry_ok;
  logic            accept;
  logic            exec;
  logic            dev_last;
  logic            cnt_last;

  // Decode the current step
  always_comb begin
    ctrl     = lmcd_pkg::microcode(pc);
    exec     = busy && (!ctrl.fetch || phase);
    dev_last = ((NW'(j) + NW'(1)) == n);
    cnt_last = (cnt == 3'd7);
    accept   = start && !busy;
    dev      = IDX_W'(n - NW'(1) - NW'(j));
  end

  assign sc.ctrl      = ctrl;
  assign sc.exec      = exec;
  assign sc.dev_last  = dev_last;
  assign sc.word_last = ctrl.emit_last && dev_last && (!ctrl.loop8 || cnt_last);
  assign sc.cnt       = cnt;

  // Pick the program entry and drop requests with an unknown command or an out-of-range pixel, row or device
  always_comb begin
    entry    = lmcd_pkg::ST_CLEAR;
    entry_ok = 1'b0;
    unique case (req.command)
      lmcd_pkg::CMD_SET_PIXEL: begin
        entry    = lmcd_pkg::ST_PIXEL;
        entry_ok = !req.pixel_x[3] && ({1'b0, req.pixel_y[5:3]} < 4'(n));
      end
      lmcd_pkg::CMD_CLEAR: begin
        entry    = lmcd_pkg::ST_CLEAR;
        entry_ok = 1'b1;
      end
      lmcd_pkg::CMD_DRAW: begin
        entry    = lmcd_pkg::ST_DRAW;
        entry_ok = 1'b1;
      end
      lmcd_pkg::CMD_BCAST_ROW: begin
        entry    = lmcd_pkg::ST_BCAST;
        entry_ok = (req.digit_row >= 4'd1) && (req.digit_row <= 4'd8);
      end
      lmcd_pkg::CMD_DEV_WRITE: begin
        entry    = lmcd_pkg::ST_DEVW;
        entry_ok = ({1'b0, req.target_device} < 4'(n));
      end
      lmcd_pkg::CMD_BLANK: begin
        entry    = lmcd_pkg::ST_BLANK;
        entry_ok = 1'b1;
      end
      lmcd_pkg::CMD_INIT: begin
        entry    = lmcd_pkg::ST_INIT_TEST;
        entry_ok = 1'b1;
      end
      default: begin
        entry    = lmcd_pkg::ST_CLEAR;
        entry_ok = 1'b0;
      end
    endcase
  end

  // Step counter, device and column loops
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      pc    <= lmcd_pkg::ST_CLEAR;
      phase <= 1'b0;
      j     <= '0;
      cnt   <= '0;
    end else if (accept) begin
      busy  <= entry_ok;
      pc    <= entry;
      phase <= 1'b0;
      j     <= '0;
      cnt   <= '0;
    end else if (busy) begin
      if (!exec) begin
        phase <= 1'b1;
      end else begin
        phase <= 1'b0;
        if (ctrl.loop_dev && !dev_last) begin
          j <= j + IDX_W'(1);
        end else begin
          j <= '0;
          if (ctrl.loop8 && !cnt_last) begin
            cnt <= cnt + 3'd1;
          end else begin
            cnt <= '0;
            if (ctrl.done) begin
              busy <= 1'b0;
            end else begin
              pc <= lmcd_pkg::step_t'(pc + 4'd1);
            end
          end
        end
      end
    end
  end

endmodule

// ===== rtl/core/lmcd_dp.sv =====
`timescale 1ns / 1ps

module lmcd_dp #(
  parameter int MAX_MODULES = 4
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        accept,
  input  lmcd_pkg::req_t              req_in,
  input  logic [$clog2(MAX_MODULES+1)-1:0] n,
  input  logic [3:0]                  brightness,
  input  logic [(MAX_MODULES > 1 ? $clog2(MAX_MODULES) : 1)-1:0] dev,
  input  lmcd_pkg::seq_ctrl_t         sc,
  output lmcd_pkg::word_t             word,
  output logic                        word_strobe
);

  localparam int NW    = $clog2(MAX_MODULES + 1);
  localparam int IDX_W = (MAX_MODULES > 1) ? $clog2(MAX_MODULES) : 1;
  localparam int ROWS  = lmcd_pkg::ROWS;

  lmcd_pkg::req_t item;

  logic [ROWS-1:0][MAX_MODULES-1:0] valid;
  logic [ROWS-1:0]                  rd_valid;
  logic [7:0]                       rd_row  [ROWS];
  logic [7:0]                       row_val [ROWS];
  logic [IDX_W-1:0]                 pix_mod;
  logic [IDX_W-1:0]                 rd_addr;
  logic                             pix_we;
  logic [7:0]                       pix_old;
  logic [7:0]                       pix_mask;
  logic [7:0]                       pix_new;
  logic [7:0]                       col_data;
  logic                             tgt_hit;
  lmcd_pkg::word_t                  word_next;

  // Hold the request for the whole program
  always_ff @(posedge clk) begin
    if (accept) begin
      item <= req_in;
    end
  end

  // Module addressed by the pixel row
  assign pix_mod = IDX_W'(n - NW'(1) - NW'(item.pixel_y[5:3]));
  assign rd_addr = sc.ctrl.pix_wr ? pix_mod : dev;
  assign pix_we  = sc.exec && sc.ctrl.pix_wr;

  // One memory per display row, all read at the same module
  for (genvar r = 0; r < ROWS; r++) begin : g_row
    lmcd_ram #(
      .WIDTH (8),
      .DEPTH (MAX_MODULES)
    ) u_row (
      .clk   (clk),
      .we    (pix_we && (item.pixel_y[2:0] == 3'(r))),
      .waddr (pix_mod),
      .wdata (pix_new),
      .raddr (rd_addr),
      .rdata (rd_row[r])
    );
    assign row_val[r] = rd_valid[r] ? rd_row[r] : 8'h00;
  end

  // Track written entries; unwritten ones read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (sc.exec && sc.ctrl.clear) begin
      for (int r = 0; r < ROWS; r++) begin
        for (int m = 0; m < MAX_MODULES; m++) begin
          if (NW'(m) < n) begin
            valid[r][m] <= 1'b0;
          end
        end
      end
    end else if (pix_we) begin
      valid[item.pixel_y[2:0]][pix_mod] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    for (int r = 0; r < ROWS; r++) begin
      rd_valid[r] <= valid[r][rd_addr];
    end
  end

  // Modify one pixel of the fetched row
  always_comb begin
    pix_old  = row_val[item.pixel_y[2:0]];
    pix_mask = 8'h80 >> item.pixel_x[2:0];
    pix_new  = item.pixel_on ? (pix_old | pix_mask) : (pix_old & ~pix_mask);
  end

  // Transpose: bit row of the column byte comes from display row 7 - row
  always_comb begin
    for (int row = 0; row < ROWS; row++) begin
      col_data[row] = row_val[ROWS-1-row][sc.cnt];
    end
  end

  assign tgt_hit = ({1'b0, item.target_device} == 4'(dev));

  // Assemble the next word
  always_comb begin
    word_next.frame_end = sc.dev_last;
    word_next.last      = sc.word_last;
    unique case (sc.ctrl.addr_sel)
      lmcd_pkg::ASEL_CONST: word_next.word_addr = sc.ctrl.const_addr;
      lmcd_pkg::ASEL_DROW:  word_next.word_addr = item.digit_row;
      lmcd_pkg::ASEL_CNT:   word_next.word_addr = {1'b0, sc.cnt} + 4'd1;
      lmcd_pkg::ASEL_TGT:   word_next.word_addr = tgt_hit ? item.target_addr
                                                          : lmcd_pkg::DRV_NOOP;
      default:              word_next.word_addr = sc.ctrl.const_addr;
    endcase
    unique case (sc.ctrl.data_sel)
      lmcd_pkg::DSEL_CONST:  word_next.word_data = sc.ctrl.const_data;
      lmcd_pkg::DSEL_PAT:    word_next.word_data = item.row_pattern;
      lmcd_pkg::DSEL_BRIGHT: word_next.word_data = {4'h0, brightness};
      lmcd_pkg::DSEL_COL:    word_next.word_data = col_data;
      lmcd_pkg::DSEL_TGT:    word_next.word_data = tgt_hit ? item.target_data : 8'h00;
      default:               word_next.word_data = sc.ctrl.const_data;
    endcase
  end

  // Output register: each word shows for one cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      word_strobe <= 1'b0;
    end else begin
      word_strobe <= sc.exec && sc.ctrl.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (sc.exec && sc.ctrl.emit) begin
      word <= word_next;
    end
  end

endmodule

// ===== rtl/core/led_matrix_chain_driver_core.sv =====
`timescale 1ns / 1ps
// The first word is registered after the request is taken; draw fetches from the frame buffer first.
// Throughput: one word per cycle, but draw does one frame buffer read before each word.
// busy stays high until the last step of the microprogram has run.
// Reset clears the frame buffer through per-entry valid bits, sets 4 devices, brightness 0.
// Words cannot be stalled: each is on word for the one cycle that word_strobe marks.

module led_matrix_chain_driver_core #(
  parameter int MAX_MODULES = 4
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  lmcd_pkg::req_t  req,
  output logic            busy,
  output lmcd_pkg::word_t word,
  output logic            word_strobe,
  input  logic            wr_en,
  input  logic [0:0]      wr_index,
  input  logic [3:0]      wr_data
);

  localparam int NW    = $clog2(MAX_MODULES + 1);
  localparam int IDX_W = (MAX_MODULES > 1) ? $clog2(MAX_MODULES) : 1;

  logic [2:0]          num_devices;
  logic [3:0]          brightness;
  logic [NW-1:0]       n;
  logic [IDX_W-1:0]    dev;
  lmcd_pkg::seq_ctrl_t sc;
  logic                accept;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      num_devices <= 3'd4;
      brightness  <= 4'd0;
    end else if (wr_en) begin
      if (wr_index == lmcd_pkg::REG_NUM_DEVICES) begin
        num_devices <= wr_data[2:0];
      end
      if (wr_index == lmcd_pkg::REG_BRIGHTNESS) begin
        brightness <= wr_data;
      end
    end
  end

  // Clamp the device count to 1..MAX_MODULES
  always_comb begin
    if (num_devices == 3'd0) begin
      n = NW'(1);
    end else if ({1'b0, num_devices} > 4'(MAX_MODULES)) begin
      n = NW'(MAX_MODULES);
    end else begin
      n = NW'(num_devices);
    end
  end

  assign accept = start && !busy;

  lmcd_seq #(
    .MAX_MODULES (MAX_MODULES)
  ) u_seq (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .req   (req),
    .n     (n),
    .busy  (busy),
    .dev   (dev),
    .sc    (sc)
  );

  lmcd_dp #(
    .MAX_MODULES (MAX_MODULES)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .req_in      (req),
    .n           (n),
    .brightness  (brightness),
    .dev         (dev),
    .sc          (sc),
    .word        (word),
    .word_strobe (word_strobe)
  );

  // Words only come out of a running program
  assert property (@(posedge clk) disable iff (rst) word_strobe |-> $past(busy))
    else $error("word strobe without a running command");

  // Only the final word of a command may end while the sequencer is idle
  assert property (@(posedge clk) disable iff (rst) (word_strobe && !word.last) |-> busy)
    else $error("command ended before its last word");

  // The last word of a command always closes a chip-select frame
  assert property (@(posedge clk) disable iff (rst)
    (word_strobe && word.last) |-> word.frame_end)
    else $error("last word does not end a frame");

endmodule
